// ----- rtl/gbfp_pkg.sv -----
// Shared types and constants of the binary frame parser.
`timescale 1ns / 1ps
package gbfp_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hB5;
  localparam logic [7:0] SYNC_SECOND  = 8'h62;
  localparam logic [7:0] CLS_TIME     = 8'h0D;
  localparam logic [7:0] CLS_NAVIG    = 8'h01;
  localparam logic [7:0] NAVID_PVT    = 8'h07;
  localparam logic [7:0] NAVID_POSLLH = 8'h02;
  localparam logic [7:0] SIGN_BIT     = 8'h80;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SUM  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN  = 3'd2;
  localparam logic [2:0] ST_BAD_CLS  = 3'd3;
  localparam logic [2:0] ST_BAD_DATE = 3'd4;
  localparam logic [2:0] ST_BAD_TIME = 3'd5;
  localparam logic [2:0] ST_NO_TIME  = 3'd6;

  localparam logic [1:0] KIND_TOS   = 2'd0;
  localparam logic [1:0] KIND_PVT   = 2'd1;
  localparam logic [1:0] KIND_POS   = 2'd2;
  localparam logic [1:0] KIND_BYLEN = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  message_kind;
    logic [55:0] datetime;
    logic [31:0] latitude;
    logic [31:0] longitude;
    logic        time_known;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ----- rtl/gbfp_front.sv -----
// Byte-serial frame decoder: sync hunt, Fletcher sum, field capture, one result per frame.
`timescale 1ns / 1ps
module gbfp_front #(
  parameter int PVT_LENGTH    = 92,
  parameter int POSLLH_LENGTH = 28,
  parameter int TOS_LENGTH    = 56
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  input  logic [7:0]              in_byte,
  output logic                    res_valid,
  output gbfp_pkg::result_t       res
);

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_CLASS, PH_ID, PH_LEN0, PH_LEN1, PH_BODY, PH_CKA, PH_CKB
  } phase_t;

  phase_t      phase;
  logic [15:0] pos, len;
  logic [7:0]  sa, sb;
  logic [1:0]  kind;
  logic [31:0] word, lat, lon;
  logic [55:0] stored, pending;
  logic        dt_valid;

  logic [7:0]  sa_next, sb_next;
  logic [31:0] word_next;
  logic [15:0] len_full, pos_next;
  logic [3:0]  dbase;
  logic [15:0] dk;
  logic        in_dt;

  assign sa_next   = sa + in_byte;
  assign sb_next   = sb + sa_next;
  assign word_next = {in_byte, word[31:8]};
  assign len_full  = {in_byte, len[7:0]};
  assign pos_next  = pos + 16'd1;
  assign dbase     = (kind == gbfp_pkg::KIND_TOS) ? 4'd8 : 4'd4;
  assign dk        = pos - 16'(dbase);
  assign in_dt     = (kind != gbfp_pkg::KIND_POS) && (pos >= 16'(dbase)) && (dk <= 16'd6);

  always_ff @(posedge clk) begin
    res_valid <= 1'b0;
    if (rst) begin
      phase    <= PH_HUNT1;
      pos      <= '0;
      len      <= '0;
      sa       <= '0;
      sb       <= '0;
      kind     <= gbfp_pkg::KIND_TOS;
      word     <= '0;
      lat      <= '0;
      lon      <= '0;
      stored   <= '0;
      pending  <= '0;
      dt_valid <= 1'b0;
    end else if (byte_valid) begin
      res.datetime   <= stored;
      res.time_known <= dt_valid;
      res.latitude   <= '0;
      res.longitude  <= '0;
      case (phase)
        PH_HUNT1: begin
          if (in_byte == gbfp_pkg::SYNC_FIRST) phase <= PH_HUNT2;
        end
        PH_HUNT2: begin
          if (in_byte == gbfp_pkg::SYNC_SECOND) begin
            sa    <= '0;
            sb    <= '0;
            phase <= PH_CLASS;
          end else if (in_byte != gbfp_pkg::SYNC_FIRST) begin
            phase <= PH_HUNT1;
          end
        end
        PH_CLASS: begin
          sa <= sa_next;
          sb <= sb_next;
          if (in_byte == gbfp_pkg::CLS_TIME) begin
            kind  <= gbfp_pkg::KIND_TOS;
            phase <= PH_ID;
          end else if (in_byte == gbfp_pkg::CLS_NAVIG) begin
            kind  <= gbfp_pkg::KIND_BYLEN;
            phase <= PH_ID;
          end else begin
            res_valid         <= 1'b1;
            res.status        <= gbfp_pkg::ST_BAD_CLS;
            res.message_kind  <= gbfp_pkg::KIND_TOS;
            phase             <= PH_HUNT1;
          end
        end
        PH_ID: begin
          sa <= sa_next;
          sb <= sb_next;
          phase <= PH_LEN0;
          if (kind != gbfp_pkg::KIND_TOS) begin
            if (in_byte == gbfp_pkg::NAVID_PVT) kind <= gbfp_pkg::KIND_PVT;
            else if (in_byte == gbfp_pkg::NAVID_POSLLH) kind <= gbfp_pkg::KIND_POS;
            else kind <= gbfp_pkg::KIND_BYLEN;
          end
        end
        PH_LEN0: begin
          sa <= sa_next;
          sb <= sb_next;
          len <= {8'd0, in_byte};
          phase <= PH_LEN1;
        end
        PH_LEN1: begin
          logic       ok;
          logic [1:0] k;
          ok = 1'b1;
          k  = kind;
          sa <= sa_next;
          sb <= sb_next;
          len <= len_full;
          if (kind == gbfp_pkg::KIND_BYLEN) begin
            if (len_full == 16'(PVT_LENGTH)) k = gbfp_pkg::KIND_PVT;
            else if (len_full == 16'(POSLLH_LENGTH)) k = gbfp_pkg::KIND_POS;
            else begin
              ok = 1'b0;
              k  = gbfp_pkg::KIND_TOS;
            end
          end else if (kind == gbfp_pkg::KIND_TOS) begin
            ok = (len_full == 16'(TOS_LENGTH));
          end else if (kind == gbfp_pkg::KIND_PVT) begin
            ok = (len_full == 16'(PVT_LENGTH));
          end else begin
            ok = (len_full == 16'(POSLLH_LENGTH));
          end
          kind <= k;
          if (!ok) begin
            res_valid        <= 1'b1;
            res.status       <= gbfp_pkg::ST_BAD_LEN;
            res.message_kind <= k;
            phase            <= PH_HUNT1;
          end else begin
            pos     <= '0;
            word    <= '0;
            lat     <= '0;
            lon     <= '0;
            pending <= '0;
            phase   <= (len_full == 16'd0) ? PH_CKA : PH_BODY;
          end
        end
        PH_BODY: begin
          logic stop;
          stop = 1'b0;
          sa   <= sa_next;
          sb   <= sb_next;
          word <= word_next;
          if (in_dt) begin
            case (dk[2:0])
              3'd0:    pending[47:40] <= in_byte;
              3'd1:    pending[55:48] <= in_byte;
              3'd2:    pending[39:32] <= in_byte;
              3'd3:    pending[31:24] <= in_byte;
              3'd4:    pending[23:16] <= in_byte;
              3'd5:    pending[15:8]  <= in_byte;
              default: pending[7:0]   <= in_byte;
            endcase
          end
          if (kind == gbfp_pkg::KIND_PVT) begin
            if (pos == 16'd11 && (!in_byte[0] || !in_byte[1])) begin
              stop = 1'b1;
              res_valid        <= 1'b1;
              res.status       <= in_byte[0] ? gbfp_pkg::ST_BAD_TIME : gbfp_pkg::ST_BAD_DATE;
              res.message_kind <= gbfp_pkg::KIND_PVT;
              phase            <= PH_HUNT1;
            end
            if (pos == 16'd27) lon <= word_next;
            if (pos == 16'd31) lat <= word_next;
          end else if (kind == gbfp_pkg::KIND_POS) begin
            if (pos == 16'd7)  lon <= word_next;
            if (pos == 16'd11) lat <= word_next;
          end
          if (!stop) begin
            pos <= pos_next;
            if (pos_next >= len) phase <= PH_CKA;
          end
        end
        PH_CKA: begin
          if (in_byte != sa) begin
            res_valid        <= 1'b1;
            res.status       <= gbfp_pkg::ST_BAD_SUM;
            res.message_kind <= kind;
            phase            <= PH_HUNT1;
          end else begin
            phase <= PH_CKB;
          end
        end
        PH_CKB: begin
          res_valid        <= 1'b1;
          res.message_kind <= kind;
          phase            <= PH_HUNT1;
          if (in_byte != sb) begin
            res.status <= gbfp_pkg::ST_BAD_SUM;
          end else if (kind == gbfp_pkg::KIND_POS) begin
            res.status    <= dt_valid ? gbfp_pkg::ST_OK : gbfp_pkg::ST_NO_TIME;
            res.latitude  <= lat;
            res.longitude <= lon;
          end else begin
            // time and PVT frames commit their date/time
            stored         <= pending;
            dt_valid       <= 1'b1;
            res.datetime   <= pending;
            res.time_known <= 1'b1;
            res.status     <= gbfp_pkg::ST_OK;
            if (kind == gbfp_pkg::KIND_PVT) begin
              res.latitude  <= lat;
              res.longitude <= lon;
            end
          end
        end
        default: phase <= PH_HUNT1;
      endcase
    end
  end

endmodule

// ----- rtl/gbfp_queue.sv -----
// Small result queue between the decoder and the output channel.
`timescale 1ns / 1ps
module gbfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_valid,
  input  gbfp_pkg::result_t       wr_data,
  output logic                    rd_valid,
  input  logic                    rd_ready,
  output gbfp_pkg::result_t       rd_data,
  output logic [$clog2(DEPTH):0]  count
);

  localparam int AW = $clog2(DEPTH);

  gbfp_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic          push, pop;

  assign rd_valid = (count != '0);
  assign pop      = rd_valid && rd_ready;
  assign push     = wr_valid;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + AW'(1);
      if (pop)  rp <= rp + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ----- rtl/gbfp_back.sv -----
// Output stage: packs a queued result onto the master stream.
`timescale 1ns / 1ps
module gbfp_back (
  input  logic              q_valid,
  output logic              q_ready,
  input  gbfp_pkg::result_t q_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [135:0]      m_tdata
);

  assign m_tvalid = q_valid;
  assign q_ready  = m_tready;
  // status, kind, year, month, day, hour, minute, second, lat, lon, known
  assign m_tdata  = {10'd0, q_data.time_known, q_data.longitude, q_data.latitude,
                     q_data.datetime[7:0], q_data.datetime[15:8], q_data.datetime[23:16],
                     q_data.datetime[31:24], q_data.datetime[39:32], q_data.datetime[55:40],
                     q_data.message_kind, q_data.status};

endmodule

// ----- rtl/gnss_binary_frame_parser.sv -----
// Top level of the binary receiver frame parser.
`timescale 1ns / 1ps
// Usage:
//   s_* carries one stream byte per beat; m_* carries one result per frame
//   (status, kind, stored date/time, raw lat/lon, time-known flag).
//   A byte is taken every cycle while the result queue has room; the decoder
//   works one byte per cycle, so a sustained rate of one byte per cycle holds.
//   A result reaches m_tvalid through the decoder's result register and then
//   the queue write.
//   Results wait in a four-entry queue; when the receiver stalls, the queue
//   fills and s_tready drops only when fewer than two free slots remain.
//   Reset clears the parser to sync hunt, empties the queue and forgets the
//   stored date/time.
//   Payload lengths are set by the PVT_LENGTH, POSLLH_LENGTH and TOS_LENGTH
//   parameters.
module gnss_binary_frame_parser #(
  parameter int PVT_LENGTH    = 92,
  parameter int POSLLH_LENGTH = 28,
  parameter int TOS_LENGTH    = 56
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // in_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0] message_kind[4:3] year[20:5] month[28:21] day[36:29] hour[44:37]
  // minute[52:45] second[60:53] latitude[92:61] longitude[124:93] time_known[125]
  output logic [135:0] m_tdata
);

  localparam int QDEPTH = 4;

  logic              res_valid, q_valid, q_ready, byte_ok;
  gbfp_pkg::result_t res, q_data;
  logic [$clog2(QDEPTH):0] count;

  // keep room for a result still in the decoder register
  assign s_tready = (count <= ($clog2(QDEPTH)+1)'(QDEPTH - 2));
  assign byte_ok  = s_tvalid && s_tready;

  gbfp_front #(
    .PVT_LENGTH(PVT_LENGTH), .POSLLH_LENGTH(POSLLH_LENGTH), .TOS_LENGTH(TOS_LENGTH)
  ) u_front (
    .clk(clk), .rst(rst), .byte_valid(byte_ok), .in_byte(s_tdata),
    .res_valid(res_valid), .res(res)
  );

  gbfp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr_valid(res_valid), .wr_data(res),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data), .count(count)
  );

  gbfp_back u_back (
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && count == ($clog2(QDEPTH)+1)'(QDEPTH) && !(m_tvalid && m_tready)))
    else $error("result queue overflow");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd7))
    else $error("status code out of range");
  a_pos_needs_time: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == gbfp_pkg::ST_OK && m_tdata[4:3] == gbfp_pkg::KIND_POS)
    |-> m_tdata[125])
    else $error("position reported ok without stored time");
`endif

endmodule
